/* hdl/spec_pkg.sv */
// Shared types and constants for the S0 pulse energy counter.
// No dependencies; used by s0_pulse_energy_counter_top.
package spec_pkg;

  // Default width of the internal energy accumulators
  localparam int ENERGY_WIDTH_DEF = 48;

  // Payload field widths
  localparam int MWH_W   = 48;
  localparam int TIME_W  = 32;
  localparam int EPP_W   = 20;
  localparam int PULSE_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_PER_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL  = 2'd3;

  // Configuration reset values
  localparam logic [EPP_W-1:0]   EPP_RST      = 20'd1000;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd10;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd1000;
  localparam logic [TIME_W-1:0]  INTERVAL_RST  = 32'd60000;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_INIT   = 1'b1;

  // Line state codes as reported on the result
  localparam logic [1:0] LS_IDLE    = 2'd0;
  localparam logic [1:0] LS_RISING  = 2'd1;
  localparam logic [1:0] LS_COUNTED = 2'd2;
  localparam logic [1:0] LS_STUCK   = 2'd3;

  // Pulse qualifier state, one-hot
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_RISING  = 4'b0010,
    ST_COUNTED = 4'b0100,
    ST_STUCK   = 4'b1000
  } qual_state_t;

  typedef struct packed {
    logic              kind;
    logic              line_level;
    logic [TIME_W-1:0] time_ms;
    logic              link_up;
    logic [MWH_W-1:0]  initial_mwh;
  } in_item_t;

  typedef struct packed {
    logic             report_valid;
    logic [MWH_W-1:0] interval_mwh;
    logic [MWH_W-1:0] total_mwh;
    logic [1:0]       line_state;
    logic             pulse_counted;
    logic             stuck_error;
    logic             total_initialized;
  } out_item_t;

endpackage

/* hdl/s0_pulse_energy_counter_top.sv */
// Top level of the S0 pulse energy counter: pulse qualifier, energy
// accumulation, periodic reports and configuration registers.
// Depends on spec_pkg.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data   (spec_pkg::in_item_t)
//   out      output     out_valid / out_ready  out_data  (spec_pkg::out_item_t)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while in_ready is high. Each accepted item is evaluated
// in the cycle it is accepted against the state registers; its result is
// written into the output register on accept. The path is 32-bit subtracts
// and compares followed by two saturating adds of ENERGY_WIDTH bits.
// Reset (rst_n low, synchronous) clears state and loads register defaults.
// in_ready stays high while the output register is empty or being drained.
// cfg_ready is always high.
module s0_pulse_energy_counter_top #(
  parameter int ENERGY_WIDTH = spec_pkg::ENERGY_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  spec_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output spec_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spec_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int EW = ENERGY_WIDTH;
  // Common width for comparing against the fixed 48-bit payload
  localparam int WW = (EW > spec_pkg::MWH_W) ? EW : spec_pkg::MWH_W;
  localparam logic [EW-1:0] E_MAX = {EW{1'b1}};

  // Configuration registers
  logic [spec_pkg::EPP_W-1:0]   epp_r;
  logic [spec_pkg::PULSE_W-1:0] min_pulse_r;
  logic [spec_pkg::PULSE_W-1:0] max_pulse_r;
  logic [spec_pkg::TIME_W-1:0]  interval_r;

  // Block state
  spec_pkg::qual_state_t        st_r, st_nxt;
  logic [spec_pkg::TIME_W-1:0]  rise_r, rise_nxt;
  logic [spec_pkg::TIME_W-1:0]  last_rpt_r, last_rpt_nxt;
  logic [EW-1:0]                pend_r, pend_nxt;
  logic [EW-1:0]                total_r, total_nxt;
  logic                         initial_seen_r, initial_seen_nxt;

  // Output register
  logic                         out_valid_r;
  spec_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                         in_fire;

  // Combinational scratch
  logic [spec_pkg::TIME_W-1:0]  elapsed;
  logic [spec_pkg::TIME_W-1:0]  since_rpt;
  logic [EW:0]                  pend_sum;
  logic [EW-1:0]                pend_add;
  logic [EW:0]                  total_sum;
  logic [WW-1:0]                init_w;
  logic [EW-1:0]                init_clamped;
  logic [WW-1:0]                interval_w;
  logic [WW-1:0]                total_w;
  logic                         counted;
  logic                         stuck;
  logic                         raised;
  logic                         report;
  logic [1:0]                   ls_code;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epp_r       <= spec_pkg::EPP_RST;
      min_pulse_r <= spec_pkg::MIN_PULSE_RST;
      max_pulse_r <= spec_pkg::MAX_PULSE_RST;
      interval_r  <= spec_pkg::INTERVAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        spec_pkg::REG_ENERGY_PER_PULSE: epp_r <= cfg_data[spec_pkg::EPP_W-1:0];
        spec_pkg::REG_MIN_PULSE:        min_pulse_r <= cfg_data[spec_pkg::PULSE_W-1:0];
        spec_pkg::REG_MAX_PULSE:        max_pulse_r <= cfg_data[spec_pkg::PULSE_W-1:0];
        spec_pkg::REG_REPORT_INTERVAL:  interval_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Evaluate one item against the current state
  always_comb begin
    st_nxt           = st_r;
    rise_nxt         = rise_r;
    last_rpt_nxt     = last_rpt_r;
    pend_nxt         = pend_r;
    total_nxt        = total_r;
    initial_seen_nxt = initial_seen_r;
    counted          = 1'b0;
    stuck            = 1'b0;
    raised           = 1'b0;
    report           = 1'b0;
    elapsed          = '0;
    since_rpt        = '0;
    pend_sum         = '0;
    pend_add         = pend_r;
    total_sum        = '0;
    init_clamped     = '0;
    init_w           = WW'(in_data.initial_mwh);

    if (in_data.kind == spec_pkg::KIND_INIT) begin
      // Initial reading: clamp to accumulator range, keep the larger total
      initial_seen_nxt = 1'b1;
      init_clamped = (init_w > WW'(E_MAX)) ? E_MAX : init_w[EW-1:0];
      if (init_clamped > total_r) begin
        total_nxt = init_clamped;
        raised    = 1'b1;
      end
    end else begin
      // Qualifier entry: low always idles, a new high records the rise
      if (!in_data.line_level) begin
        st_nxt = spec_pkg::ST_IDLE;
      end else if (st_r == spec_pkg::ST_IDLE) begin
        st_nxt   = spec_pkg::ST_RISING;
        rise_nxt = in_data.time_ms;
      end
      elapsed = in_data.time_ms - rise_nxt;

      // At most one timeout per sample
      pend_sum = {1'b0, pend_r} + (EW + 1)'(epp_r);
      case (st_nxt)
        spec_pkg::ST_RISING: begin
          if (elapsed > spec_pkg::TIME_W'(min_pulse_r)) begin
            st_nxt   = spec_pkg::ST_COUNTED;
            pend_add = pend_sum[EW] ? E_MAX : pend_sum[EW-1:0];
            counted  = 1'b1;
          end
        end
        spec_pkg::ST_COUNTED: begin
          if (elapsed > spec_pkg::TIME_W'(max_pulse_r)) begin
            st_nxt = spec_pkg::ST_STUCK;
            stuck  = 1'b1;
          end
        end
        default: ;
      endcase
      pend_nxt = pend_add;

      // Periodic report folds pending energy into the total
      since_rpt = in_data.time_ms - last_rpt_r;
      total_sum = {1'b0, total_r} + {1'b0, pend_add};
      if (in_data.link_up && initial_seen_r && (since_rpt > interval_r)) begin
        report       = 1'b1;
        last_rpt_nxt = in_data.time_ms;
        total_nxt    = total_sum[EW] ? E_MAX : total_sum[EW-1:0];
        pend_nxt     = '0;
      end
    end

    // Reported line state code
    case (st_nxt)
      spec_pkg::ST_IDLE:    ls_code = spec_pkg::LS_IDLE;
      spec_pkg::ST_RISING:  ls_code = spec_pkg::LS_RISING;
      spec_pkg::ST_COUNTED: ls_code = spec_pkg::LS_COUNTED;
      spec_pkg::ST_STUCK:   ls_code = spec_pkg::LS_STUCK;
      default:              ls_code = spec_pkg::LS_IDLE;
    endcase

    // Without a report the interval field shows the pending energy
    interval_w = WW'(pend_add);
    if (in_data.kind == spec_pkg::KIND_INIT) interval_w = WW'(pend_r);
    total_w = WW'(total_nxt);

    out_data_nxt.report_valid      = report;
    out_data_nxt.interval_mwh      = interval_w[spec_pkg::MWH_W-1:0];
    out_data_nxt.total_mwh         = total_w[spec_pkg::MWH_W-1:0];
    out_data_nxt.line_state        = ls_code;
    out_data_nxt.pulse_counted     = counted;
    out_data_nxt.stuck_error       = stuck;
    out_data_nxt.total_initialized = raised;
  end

  // State update on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= spec_pkg::ST_IDLE;
      rise_r         <= '0;
      last_rpt_r     <= '0;
      pend_r         <= '0;
      total_r        <= '0;
      initial_seen_r <= 1'b0;
    end else if (in_fire) begin
      st_r           <= st_nxt;
      rise_r         <= rise_nxt;
      last_rpt_r     <= last_rpt_nxt;
      pend_r         <= pend_nxt;
      total_r        <= total_nxt;
      initial_seen_r <= initial_seen_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.pulse_counted && out_data.stuck_error))
    else $error("pulse counted and stuck flagged on one item");

  a_init_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.kind == spec_pkg::KIND_INIT) |=>
      (out_valid && !out_data.report_valid && !out_data.pulse_counted))
    else $error("initial reading produced report or pulse");

  a_report_needs_init: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.report_valid) |-> initial_seen_r)
    else $error("report before initial reading");

  a_counted_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pulse_counted) |-> (out_data.line_state == spec_pkg::LS_COUNTED))
    else $error("pulse counted without counted state");

endmodule
